### rtl/scp_pkg.sv
// scp_pkg: shared types, constants and q30 helpers for the sine/cosine pipeline.
// used by scp_reduce, scp_poly, sine_cosine_polynomial and scp_checker; no dependencies.
package scp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF  = 16;
    localparam int RESULT_FRAC_BITS_DEF = 16;

    // cycles from an accepting edge to the edge that takes the result
    localparam int SCP_LATENCY = 15;

    localparam int MAG_W  = 31;
    localparam int PROD_W = 2 * MAG_W;
    localparam int Q30_W  = 34;
    localparam int OUT_W  = 18;

    typedef logic signed [Q30_W-1:0] t_q30;

    // 2/pi as unsigned q0.32, pi/2 as unsigned q1.32
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [32:0] PI_OVER_2_Q32   = 33'd6746518852;

    localparam t_q30 ONE_Q30 = 34'sd1073741824;
    localparam t_q30 SIN_C0  = 34'sd1073736445;
    localparam t_q30 SIN_C1  = -34'sd178887074;
    localparam t_q30 SIN_C2  = 34'sd8720387;
    localparam t_q30 COS_C0  = -34'sd536869372;
    localparam t_q30 COS_C1  = 34'sd44726738;
    localparam t_q30 COS_C2  = -34'sd1458769;

    // reduced argument handed from reduction to polynomial section
    typedef struct packed {
        logic [1:0]       k;     // bit 0: cosine polynomial, bit 1: negate
        logic             rneg;  // reduced argument is negative
        logic [MAG_W-1:0] u;     // |reduced argument| in q30
    } t_red;

    // round a q60 magnitude product to q30, half away from zero, then apply sign
    function automatic t_q30 rnd_q30(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W:0] s;
        t_q30            m;
        s = {1'b0, p} + (PROD_W + 1)'(1 << 29);
        m = t_q30'(s >> 30);
        return neg ? -m : m;
    endfunction

    function automatic logic [MAG_W-1:0] mag_q30(input t_q30 v);
        t_q30 a;
        a = v[Q30_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

### rtl/scp_reduce.sv
// scp_reduce: quadrant reduction of the angle, six register stages.
// depends on scp_pkg.
module scp_reduce #(
    parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic                i_op,
    input  logic signed [31:0]  i_angle,
    output logic                o_vld,
    output scp_pkg::t_red       o_red
);

    localparam int SH = 32 + ANGLE_FRAC_BITS;
    localparam int QW = 32 - ANGLE_FRAC_BITS;
    localparam int DW = 66;
    localparam int RW = 36;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic        r1_op;
    logic [31:0] r1_angle;

    logic [63:0] r2_p, n2_p;
    logic [31:0] r2_ma, n2_ma;
    logic        r2_aneg, r2_op;

    logic [QW-1:0] r3_qm, n3_qm;
    logic [31:0]   r3_ma;
    logic          r3_aneg, r3_op;

    logic [QW+32:0] r4_prod, n4_prod;
    logic [31:0]    r4_ma;
    logic           r4_aneg;
    logic [1:0]     r4_k, n4_k, n4_qlow;

    logic signed [RW-1:0] r5_d, n5_d;
    logic [DW-1:0]        n5_full;
    logic                 r5_aneg;
    logic [1:0]           r5_k;

    scp_pkg::t_red r6_red, n6_red;
    logic [RW-1:0] n6_mag, n6_sum;

    function automatic logic [RW-1:0] n5_dmag(input logic signed [RW-1:0] v);
        return v[RW-1] ? RW'(-v) : RW'(v);
    endfunction

    // stage 2: magnitude of the angle times 2/pi; -(-2^31) wraps to 2^31 unsigned
    assign n2_ma = r1_angle[31] ? (32'd0 - r1_angle) : r1_angle;
    assign n2_p  = n2_ma * scp_pkg::TWO_OVER_PI_Q32;

    // stage 3: round quotient half to even
    always_comb begin
        logic inc;
        inc   = r2_p[SH-1] & ((|r2_p[SH-2:0]) | r2_p[SH]);
        n3_qm = r2_p[63:SH] + QW'(inc);
    end

    // stage 4: q times pi/2, quadrant from the signed quotient
    assign n4_prod = r3_qm * scp_pkg::PI_OVER_2_Q32;
    assign n4_qlow = r3_aneg ? (2'd0 - r3_qm[1:0]) : r3_qm[1:0];
    assign n4_k    = n4_qlow + {1'b0, r3_op};

    // stage 5: remainder in q32, always small enough for RW bits
    assign n5_full = (DW'(r4_ma) << (32 - ANGLE_FRAC_BITS)) - DW'(r4_prod);
    assign n5_d    = $signed(n5_full[RW-1:0]);

    // stage 6: q30 magnitude, half up; sign follows the angle
    always_comb begin
        n6_mag      = n5_dmag(r5_d);
        n6_sum      = n6_mag + RW'(2);
        n6_red.u    = n6_sum[scp_pkg::MAG_W+1:2];
        n6_red.k    = r5_k;
        n6_red.rneg = r5_aneg ? (!r5_d[RW-1] && (|r5_d)) : r5_d[RW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op    <= i_op;
        r1_angle <= i_angle;

        r2_p     <= n2_p;
        r2_ma    <= n2_ma;
        r2_aneg  <= r1_angle[31];
        r2_op    <= r1_op;

        r3_qm    <= n3_qm;
        r3_ma    <= r2_ma;
        r3_aneg  <= r2_aneg;
        r3_op    <= r2_op;

        r4_prod  <= n4_prod;
        r4_ma    <= r3_ma;
        r4_aneg  <= r3_aneg;
        r4_k     <= n4_k;

        r5_d     <= n5_d;
        r5_aneg  <= r4_aneg;
        r5_k     <= r4_k;

        r6_red   <= n6_red;
    end

    assign o_vld = r_v6;
    assign o_red = r6_red;

endmodule

### rtl/scp_poly.sv
// scp_poly: horner evaluation of the sine or cosine polynomial, eight register stages.
// depends on scp_pkg.
module scp_poly (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  scp_pkg::t_red  i_red,
    output logic           o_vld,
    output scp_pkg::t_q30  o_y
);

    localparam int MW = scp_pkg::MAG_W;
    localparam int PW = scp_pkg::PROD_W;

    logic [7:0] r_v;

    // k and sign travel with stages 1 to 7
    logic [1:0] r_k [1:7];
    logic       r_rneg [1:7];
    logic [MW-1:0] r_u [1:6];

    logic [PW-1:0] r1_pxx, n1_pxx;
    logic [MW-1:0] r2_xx, n2_xx;
    logic [MW-1:0] r3_xx, r4_xx, r5_xx, r6_xx;

    logic [PW-1:0] r3_m1, n3_m1;
    logic          r3_neg, n3_neg;
    scp_pkg::t_q30 r4_t1, n4_t1;
    logic [PW-1:0] r5_m2, n5_m2;
    logic          r5_neg;
    scp_pkg::t_q30 r6_t2, n6_t2;
    logic [PW-1:0] r7_m3, n7_m3;
    logic          r7_neg;
    scp_pkg::t_q30 r8_y, n8_y;

    scp_pkg::t_q30 c2_sel;
    logic [MW-1:0] n7_b;

    assign n1_pxx = i_red.u * i_red.u;
    assign n2_xx  = MW'(scp_pkg::mag_q30(scp_pkg::rnd_q30(r1_pxx, 1'b0)));

    assign c2_sel = r_k[2][0] ? scp_pkg::COS_C2 : scp_pkg::SIN_C2;
    assign n3_m1  = r2_xx * scp_pkg::mag_q30(c2_sel);
    assign n3_neg = c2_sel[scp_pkg::Q30_W-1];

    assign n4_t1 = (r_k[3][0] ? scp_pkg::COS_C1 : scp_pkg::SIN_C1)
                 + scp_pkg::rnd_q30(r3_m1, r3_neg);

    assign n5_m2 = r4_xx * scp_pkg::mag_q30(r4_t1);

    assign n6_t2 = (r_k[5][0] ? scp_pkg::COS_C0 : scp_pkg::SIN_C0)
                 + scp_pkg::rnd_q30(r5_m2, r5_neg);

    // sine closes with x, cosine with x squared
    assign n7_b  = r_k[6][0] ? r6_xx : r_u[6];
    assign n7_m3 = n7_b * scp_pkg::mag_q30(r6_t2);

    always_comb begin
        scp_pkg::t_q30 y0;
        logic          flip;
        y0   = scp_pkg::rnd_q30(r7_m3, r7_neg)
             + (r_k[7][0] ? scp_pkg::ONE_Q30 : scp_pkg::t_q30'(0));
        // sine is odd in the reduced argument, cosine even
        flip = r_k[7][1] ^ (!r_k[7][0] && r_rneg[7]);
        n8_y = flip ? -y0 : y0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_k[1]    <= i_red.k;
        r_rneg[1] <= i_red.rneg;
        r_u[1]    <= i_red.u;
        for (int s = 2; s <= 7; s++) begin
            r_k[s]    <= r_k[s-1];
            r_rneg[s] <= r_rneg[s-1];
        end
        for (int s = 2; s <= 6; s++) begin
            r_u[s] <= r_u[s-1];
        end

        r1_pxx <= n1_pxx;
        r2_xx  <= n2_xx;
        r3_xx  <= r2_xx;
        r4_xx  <= r3_xx;
        r5_xx  <= r4_xx;
        r6_xx  <= r5_xx;

        r3_m1  <= n3_m1;
        r3_neg <= n3_neg;
        r4_t1  <= n4_t1;
        r5_m2  <= n5_m2;
        r5_neg <= r4_t1[scp_pkg::Q30_W-1];
        r6_t2  <= n6_t2;
        r7_m3  <= n7_m3;
        r7_neg <= r6_t2[scp_pkg::Q30_W-1];
        r8_y   <= n8_y;
    end

    assign o_vld = r_v[7];
    assign o_y   = r8_y;

endmodule

### rtl/sine_cosine_polynomial.sv
// sine_cosine_polynomial: fixed-point sine/cosine with quadrant reduction.
// the result strobe follows the reduction stages, the polynomial stages and the output register.
// throughput: one word per cycle; busy is held low, start is taken every cycle.
// the 32x32 multiply by 2/pi and the chain of four q30 multiplies set the depth.
// synchronous active-low reset clears the valid pipeline; payload is not reset.
// depends on scp_pkg, scp_reduce, scp_poly.
module sine_cosine_polynomial #(
    parameter int ANGLE_FRAC_BITS  = scp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic signed [31:0]                  i_angle,
    output logic                                o_valid,
    output logic signed [scp_pkg::OUT_W-1:0]    o_value
);

    localparam int YW = scp_pkg::Q30_W;
    localparam int RS = 30 - RESULT_FRAC_BITS;
    localparam logic [YW-1:0] RND_OUT = (YW'(1) << RS) >> 1;
    localparam logic [YW-1:0] ONE_OUT = YW'(1) << RESULT_FRAC_BITS;

    logic          red_vld;
    scp_pkg::t_red red;
    logic          y_vld;
    scp_pkg::t_q30 y;

    logic                              r_valid;
    logic signed [scp_pkg::OUT_W-1:0]  r_value, n_value;

    assign busy = 1'b0;

    scp_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_op    (i_op),
        .i_angle (i_angle),
        .o_vld   (red_vld),
        .o_red   (red)
    );

    scp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (red_vld),
        .i_red   (red),
        .o_vld   (y_vld),
        .o_y     (y)
    );

    // round to the output format, saturate magnitude to one
    always_comb begin
        logic [YW-1:0] ym;
        logic [YW-1:0] yr;
        logic [YW-1:0] res;
        ym = y[YW-1] ? YW'(-y) : YW'(y);
        yr = (ym + RND_OUT) >> RS;
        if (yr > ONE_OUT) begin
            yr = ONE_OUT;
        end
        res     = y[YW-1] ? (YW'(0) - yr) : yr;
        n_value = $signed(res[scp_pkg::OUT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= y_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

### rtl/scp_checker.sv
// scp_checker: port-level assertions for sine_cosine_polynomial, bound to the top level.
// depends on scp_pkg.
module scp_checker #(
    parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_op,
    input logic signed [31:0]                i_angle,
    input logic                              o_valid,
    input logic signed [scp_pkg::OUT_W-1:0]  o_value
);

    localparam int LAT = scp_pkg::SCP_LATENCY;
    localparam logic signed [scp_pkg::OUT_W-1:0] ONE_OUT =
        scp_pkg::OUT_W'(1) << RESULT_FRAC_BITS;

    // every accepted word comes out after the fixed latency
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word produced no result strobe");

    // no strobe without a word accepted exactly the package latency before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without matching accepted word");

    a_sin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_op && i_angle == 32'sd0) |-> ##LAT (o_value == '0))
        else $error("sine of zero is not zero");

    a_cos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op && i_angle == 32'sd0) |-> ##LAT (o_value == ONE_OUT))
        else $error("cosine of zero is not one");

    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind sine_cosine_polynomial scp_checker #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_scp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_op    (i_op),
    .i_angle (i_angle),
    .o_valid (o_valid),
    .o_value (o_value)
);
